// File: design/tes_pkg.sv
package tes_pkg;

  localparam logic [1:0] FMT_XML_A = 2'd0;
  localparam logic [1:0] FMT_XML_B = 2'd1;
  localparam logic [1:0] FMT_JSON  = 2'd2;
  localparam logic [1:0] FMT_CSV   = 2'd3;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;

  localparam logic [15:0] CAPACITY_RESET = 16'd4096;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_BSL  = 8'h5C;

  // Replacement text, first byte in the top octet
  typedef struct packed {
    logic [2:0]  len;
    logic [63:0] text;
  } rep_t;

  // One classified character handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] fmt;
    logic [2:0] len;
    logic       close;
    logic       cap_nz;
    logic       halt;
  } desc_t;

  function automatic rep_t mk_rep(input logic [2:0] l, input logic [63:0] t);
    rep_t r;
    r.len  = l;
    r.text = t;
    return r;
  endfunction

  function automatic rep_t rep_lookup(input logic [1:0] fmt, input logic [7:0] c);
    rep_t r;
    r = mk_rep(3'd1, {c, 56'd0});
    unique case (fmt)
      FMT_XML_A, FMT_XML_B: begin
        unique case (c)
          CH_LT:   r = mk_rep(3'd4, {"&lt;", 32'd0});
          CH_GT:   r = mk_rep(3'd4, {"&gt;", 32'd0});
          CH_AMP:  r = mk_rep(3'd5, {"&amp;", 24'd0});
          CH_CR:   r = mk_rep(3'd5, {"&#13;", 24'd0});
          CH_LF:   r = mk_rep(3'd5, {"&#10;", 24'd0});
          CH_QUOT: r = mk_rep(3'd6, {"&quot;", 16'd0});
          default: r = mk_rep(3'd1, {c, 56'd0});
        endcase
      end
      FMT_JSON: begin
        unique case (c)
          CH_BSL:  r = mk_rep(3'd2, {"\\\\", 48'd0});
          CH_QUOT: r = mk_rep(3'd2, {"\\\"", 48'd0});
          CH_CR:   r = mk_rep(3'd2, {"\\r", 48'd0});
          CH_LF:   r = mk_rep(3'd2, {"\\n", 48'd0});
          default: r = mk_rep(3'd1, {c, 56'd0});
        endcase
      end
      FMT_CSV: begin
        unique case (c)
          CH_QUOT: r = mk_rep(3'd2, {"\"\"", 48'd0});
          default: r = mk_rep(3'd1, {c, 56'd0});
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rep_byte(input logic [63:0] text, input logic [2:0] pos);
    logic [2:0] slot;
    slot = 3'd7 - pos;
    return text[{slot, 3'b000} +: 8];
  endfunction

endpackage

// File: design/tes_front.sv
module tes_front #(
  parameter int COUNT_BITS      = 16,
  parameter int MAX_REPLACEMENT = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_char_in,
  input  logic                   in_last_char,
  input  logic                   in_empty_string,
  input  logic                   q_full,
  output logic                   push,
  output tes_pkg::desc_t         push_desc,
  output logic [COUNT_BITS-1:0]  push_chars,
  output logic [COUNT_BITS-1:0]  push_bytes
);
  import tes_pkg::*;

  localparam logic [3:0] MAXR = 4'(MAX_REPLACEMENT);

  logic [1:0]            fmt_r, fmt_nxt;
  logic [15:0]           cap_r, cap_nxt;
  logic [15:0]           space_r, space_nxt;
  logic                  halt_r, halt_nxt;
  logic [COUNT_BITS-1:0] chars_r, chars_nxt;
  logic [COUNT_BITS-1:0] bytes_r, bytes_nxt;

  rep_t                  rep;
  logic                  take, fits, close;
  logic [15:0]           space_new, space_init;
  logic                  halt_new;
  logic [COUNT_BITS-1:0] chars_new, bytes_new;
  logic [2:0]            d_len;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    rep        = rep_lookup(fmt_r, in_char_in);
    take       = !in_empty_string && !halt_r;
    fits       = (16'(rep.len) <= space_r) && ({1'b0, rep.len} <= MAXR);
    close      = in_empty_string || in_last_char;
    space_init = (cap_r != 16'd0) ? cap_r - 16'd1 : 16'd0;

    space_new = space_r;
    halt_new  = halt_r;
    chars_new = chars_r;
    bytes_new = bytes_r;
    d_len     = 3'd0;
    if (take) begin
      if (fits) begin
        space_new = space_r - 16'(rep.len);
        chars_new = chars_r + COUNT_BITS'(1);
        bytes_new = bytes_r + COUNT_BITS'(rep.len);
        d_len     = rep.len;
      end else begin
        halt_new = 1'b1;
      end
    end

    push_desc.ch     = in_char_in;
    push_desc.fmt    = fmt_r;
    push_desc.len    = d_len;
    push_desc.close  = close;
    push_desc.cap_nz = (cap_r != 16'd0);
    push_desc.halt   = halt_new;
    push_chars       = chars_new;
    push_bytes       = bytes_new;

    fmt_nxt   = fmt_r;
    cap_nxt   = cap_r;
    space_nxt = space_r;
    halt_nxt  = halt_r;
    chars_nxt = chars_r;
    bytes_nxt = bytes_r;

    if (cfg_we && (cfg_index == REG_FORMAT || cfg_index == REG_CAPACITY)) begin
      if (cfg_index == REG_FORMAT) begin
        fmt_nxt   = cfg_wdata[1:0];
        space_nxt = space_init;
      end else begin
        cap_nxt   = cfg_wdata;
        space_nxt = (cfg_wdata != 16'd0) ? cfg_wdata - 16'd1 : 16'd0;
      end
      halt_nxt  = 1'b0;
      chars_nxt = '0;
      bytes_nxt = '0;
    end else if (push) begin
      if (close) begin
        space_nxt = space_init;
        halt_nxt  = 1'b0;
        chars_nxt = '0;
        bytes_nxt = '0;
      end else begin
        space_nxt = space_new;
        halt_nxt  = halt_new;
        chars_nxt = chars_new;
        bytes_nxt = bytes_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_XML_A;
      cap_r   <= CAPACITY_RESET;
      space_r <= CAPACITY_RESET - 16'd1;
      halt_r  <= 1'b0;
      chars_r <= '0;
      bytes_r <= '0;
    end else begin
      fmt_r   <= fmt_nxt;
      cap_r   <= cap_nxt;
      space_r <= space_nxt;
      halt_r  <= halt_nxt;
      chars_r <= chars_nxt;
      bytes_r <= bytes_nxt;
    end
  end

endmodule

// File: design/tes_queue.sv
module tes_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  import tes_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + PTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + PTR_W'(1)) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/tes_back.sv
module tes_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  tes_pkg::desc_t        head_desc,
  input  logic [COUNT_BITS-1:0] head_chars,
  input  logic [COUNT_BITS-1:0] head_bytes,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic                  out_end_of_item,
  output logic                  out_end_of_string,
  output logic                  out_halted,
  output logic [15:0]           out_consumed_count,
  output logic [15:0]           out_written_count
);
  import tes_pkg::*;

  localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [2:0]  pos_r, pos_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic        bvalid_r, eoi_r, eos_r, halt_r;
  logic [15:0] chars_out_r, bytes_out_r;

  rep_t            rep;
  logic            in_rep, load, produce;
  logic [7:0]      byte_c;
  logic            bvalid_c, eoi_c, eos_c;
  logic [WIDE-1:0] chars_w, bytes_w;

  always_comb begin
    rep      = rep_lookup(head_desc.fmt, head_desc.ch);
    in_rep   = pos_r < head_desc.len;
    byte_c   = in_rep ? rep_byte(rep.text, pos_r) : 8'd0;
    bvalid_c = in_rep || (head_desc.close && head_desc.cap_nz);
    eos_c    = !in_rep && head_desc.close;
    eoi_c    = in_rep ? ((pos_r == head_desc.len - 3'd1) && !head_desc.close) : 1'b1;
    chars_w  = WIDE'(head_chars);
    bytes_w  = WIDE'(head_bytes);

    load    = !valid_r || !out_stall;
    produce = !q_empty && load;
    pop     = produce && eoi_c;

    pos_nxt   = produce ? (eoi_c ? 3'd0 : pos_r + 3'd1) : pos_r;
    valid_nxt = load ? !q_empty : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      byte_r      <= byte_c;
      bvalid_r    <= bvalid_c;
      eoi_r       <= eoi_c;
      eos_r       <= eos_c;
      halt_r      <= head_desc.halt;
      chars_out_r <= chars_w[15:0];
      bytes_out_r <= bytes_w[15:0];
    end
  end

  assign out_valid          = valid_r;
  assign out_byte           = byte_r;
  assign out_byte_valid     = bvalid_r;
  assign out_end_of_item    = eoi_r;
  assign out_end_of_string  = eos_r;
  assign out_halted         = halt_r;
  assign out_consumed_count = chars_out_r;
  assign out_written_count  = bytes_out_r;

endmodule

// File: design/text_escape_streamer_core.sv
// String escaper for XML, JSON and CSV text.
// Input channel: one character per beat (in_valid/in_stall), with in_last_char
// closing the string, or in_empty_string closing it without a character.
// Output channel: one escaped byte per beat (out_valid/out_stall); each input
// beat gives one to seven output beats, the last flagged out_end_of_item, and
// the closing beat (NUL terminator) flagged out_end_of_string with the counts.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 format, index 1 output
// capacity; a write restarts the current string, and the user must do it
// only when idle, as the block does not enforce it. The front classifies a
// character and updates the space and counts in the cycle it is taken, then
// hands it to a four-entry queue. The back expands each queued character one
// output byte per cycle into the output register while out_stall is low.
// The first result passes through the queue entry and then the output
// register. Each replacement byte and each closing terminator is its own
// output beat; input is stalled only when the queue fills behind them.
// Reset empties the queue and output register and loads XML format with a
// capacity of 4096. A stalled receiver holds the output beat; the queue then
// fills and in_stall rises.
module text_escape_streamer_core #(
  parameter int COUNT_BITS      = 16,
  parameter int MAX_REPLACEMENT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_last_char,
  input  logic        in_empty_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_item,
  output logic        out_end_of_string,
  output logic        out_halted,
  output logic [15:0] out_consumed_count,
  output logic [15:0] out_written_count
);
  import tes_pkg::*;

  localparam int DW = $bits(desc_t);
  localparam int QW = DW + 2 * COUNT_BITS;

  logic                  push, pop, q_full, q_empty;
  desc_t                 push_desc, head_desc;
  logic [COUNT_BITS-1:0] push_chars, push_bytes, head_chars, head_bytes;
  logic [QW-1:0]         push_data, pop_data;

  tes_front #(
    .COUNT_BITS      (COUNT_BITS),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .in_last_char    (in_last_char),
    .in_empty_string (in_empty_string),
    .q_full          (q_full),
    .push            (push),
    .push_desc       (push_desc),
    .push_chars      (push_chars),
    .push_bytes      (push_bytes)
  );

  assign push_data  = {push_desc, push_chars, push_bytes};
  assign head_desc  = desc_t'(pop_data[QW-1 -: DW]);
  assign head_chars = pop_data[2*COUNT_BITS-1 -: COUNT_BITS];
  assign head_bytes = pop_data[COUNT_BITS-1:0];

  tes_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tes_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .head_desc          (head_desc),
    .head_chars         (head_chars),
    .head_bytes         (head_bytes),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_end_of_item    (out_end_of_item),
    .out_end_of_string  (out_end_of_string),
    .out_halted         (out_halted),
    .out_consumed_count (out_consumed_count),
    .out_written_count  (out_written_count)
  );

`ifndef ASSERT_OFF
  a_eos_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_end_of_item)
    else $error("closing beat without end of item");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid && !out_end_of_string |->
      out_byte == 8'd0 && out_end_of_item)
    else $error("drop marker malformed");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue popped while empty");
`endif

endmodule
